/* rtl/cst_pkg.sv */
package cst_pkg;

  localparam int NumSemaphores = 8;
  localparam int WaitDepth     = 8;
  localparam int CountBits     = 16;

  // Fixed field widths of the command and response channels
  localparam int CmdW    = 3;
  localparam int HandleW = 3;
  localparam int InitW   = 16;
  localparam int TaskW   = 5;
  localparam int StatusW = 3;
  localparam int CountW  = 16;

  localparam int SlotW  = (NumSemaphores > 1) ? $clog2(NumSemaphores) : 1;
  localparam int QposW  = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int TotalW = $clog2(WaitDepth + 1);
  localparam int SumW   = $clog2(2 * WaitDepth);
  localparam int StoreDepth = NumSemaphores * WaitDepth;
  localparam int StoreAddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  typedef logic [SlotW-1:0]      slot_t;
  typedef logic [QposW-1:0]      qpos_t;
  typedef logic [TotalW-1:0]     total_t;
  typedef logic [CountBits-1:0]  count_t;
  typedef logic [StoreAddrW-1:0] store_addr_t;

  localparam count_t CountMax = {CountBits{1'b1}};

  typedef enum logic [CmdW-1:0] {
    CmdCreate   = 3'd0,
    CmdDestroy  = 3'd1,
    CmdWait     = 3'd2,
    CmdSignal   = 3'd3,
    CmdGetCount = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 3'd0,
    StNoSlot    = 3'd1,
    StBadHandle = 3'd2,
    StQueueFull = 3'd3,
    StSaturated = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the command and start the waiter read
    logic exec;  // update the slot and load the response register
  } cst_ctrl_t;

endpackage

/* rtl/cst_if.sv */
interface cst_cmd_if import cst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [HandleW-1:0] handle;
  logic [InitW-1:0]   start_count;
  logic [TaskW-1:0]   task_id;

  modport source (output valid, command, handle, start_count, task_id, input ready);
  modport sink   (input valid, command, handle, start_count, task_id, output ready);
endinterface

interface cst_rsp_if import cst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [HandleW-1:0] new_handle;
  logic [CountW-1:0]  count_value;
  logic               blocked;
  logic               wake_valid;
  logic [TaskW-1:0]   woken_task;

  modport source (output valid, status, new_handle, count_value, blocked, wake_valid,
                  woken_task, input ready);
  modport sink   (input valid, status, new_handle, count_value, blocked, wake_valid,
                  woken_task, output ready);
endinterface

/* rtl/cst_ram.sv */
module cst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cst_ctrl.sv */
module cst_ctrl import cst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cst_ctrl_t ctrl_o
);

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  // Take a transaction only when the response register is free by the next edge
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign ctrl_o.load = accept;
  assign ctrl_o.exec = (state_q == StExec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

/* rtl/cst_dp.sv */
module cst_dp import cst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_ctrl_t          ctrl_i,
  input  logic [CmdW-1:0]    command_i,
  input  logic [HandleW-1:0] handle_i,
  input  logic [InitW-1:0]   start_count_i,
  input  logic [TaskW-1:0]   task_id_i,
  output logic [StatusW-1:0] status_o,
  output logic [HandleW-1:0] new_handle_o,
  output logic [CountW-1:0]  count_value_o,
  output logic               blocked_o,
  output logic               wake_valid_o,
  output logic [TaskW-1:0]   woken_task_o
);

  // Slot table
  logic   used_q  [NumSemaphores];
  count_t count_q [NumSemaphores];
  total_t total_q [NumSemaphores];
  qpos_t  head_q  [NumSemaphores];

  // Captured command
  logic [CmdW-1:0]    cmd_q;
  logic [HandleW-1:0] handle_q;
  count_t             init_q;
  logic [TaskW-1:0]   task_q;

  // Response register
  logic [StatusW-1:0] status_q;
  logic [HandleW-1:0] new_handle_q;
  logic [CountW-1:0]  count_value_q;
  logic               blocked_q;
  logic               wake_valid_q;
  logic [TaskW-1:0]   woken_task_q;

  // Waiter store
  slot_t            in_slot;
  store_addr_t      rd_addr;
  logic             wr_en;
  store_addr_t      wr_addr;
  logic [TaskW-1:0] rd_task;

  // Execute-stage signals
  slot_t             slot;
  logic              hit;
  logic              free_found;
  slot_t             free_slot;
  count_t            cur_count;
  total_t            cur_total;
  qpos_t             cur_head;
  logic [SumW-1:0]   tail_sum;
  qpos_t             tail_pos;
  qpos_t             head_next;

  logic              upd_en;
  slot_t             upd_slot;
  logic              upd_used;
  count_t            upd_count;
  total_t            upd_total;
  qpos_t             upd_head;

  logic [StatusW-1:0] status_d;
  logic [HandleW-1:0] new_handle_d;
  logic [CountW-1:0]  count_value_d;
  logic               blocked_d;
  logic               wake_valid_d;
  logic [TaskW-1:0]   woken_task_d;

  // Issue the read of the oldest waiter of the addressed slot at capture time
  assign in_slot = SlotW'(handle_i);
  assign rd_addr = StoreAddrW'(in_slot) * StoreAddrW'(WaitDepth)
                 + StoreAddrW'(head_q[in_slot]);

  cst_ram #(
    .Width (TaskW),
    .Depth (StoreDepth)
  ) u_waiters (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (task_q),
    .raddr_i (rd_addr),
    .rdata_o (rd_task)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= command_i;
      handle_q <= handle_i;
      init_q   <= CountBits'(start_count_i);
      task_q   <= task_id_i;
    end
  end

  assign slot      = SlotW'(handle_q);
  assign hit       = (32'(handle_q) < 32'(NumSemaphores)) && used_q[slot];
  assign cur_count = count_q[slot];
  assign cur_total = total_q[slot];
  assign cur_head  = head_q[slot];

  // Queue tail and head advance, both wrapped at the queue depth
  always_comb begin
    tail_sum = SumW'(cur_head) + SumW'(cur_total);
    if (tail_sum >= SumW'(WaitDepth)) begin
      tail_sum = tail_sum - SumW'(WaitDepth);
    end
    tail_pos = QposW'(tail_sum);
    if (cur_head == QposW'(WaitDepth - 1)) begin
      head_next = '0;
    end else begin
      head_next = cur_head + QposW'(1);
    end
  end

  assign wr_addr = StoreAddrW'(slot) * StoreAddrW'(WaitDepth) + StoreAddrW'(tail_pos);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NumSemaphores - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  always_comb begin
    upd_en        = 1'b0;
    upd_slot      = slot;
    upd_used      = used_q[slot];
    upd_count     = cur_count;
    upd_total     = cur_total;
    upd_head      = cur_head;
    wr_en         = 1'b0;
    status_d      = StOk;
    new_handle_d  = '0;
    count_value_d = '0;
    blocked_d     = 1'b0;
    wake_valid_d  = 1'b0;
    woken_task_d  = '0;

    case (cmd_e'(cmd_q))
      CmdCreate: begin
        if (free_found) begin
          upd_en        = ctrl_i.exec;
          upd_slot      = free_slot;
          upd_used      = 1'b1;
          upd_count     = init_q;
          upd_total     = '0;
          upd_head      = '0;
          new_handle_d  = HandleW'(free_slot);
          count_value_d = CountW'(init_q);
        end else begin
          status_d = StNoSlot;
        end
      end
      CmdDestroy, CmdWait, CmdSignal, CmdGetCount: begin
        if (!hit) begin
          status_d = StBadHandle;
        end else begin
          case (cmd_e'(cmd_q))
            CmdDestroy: begin
              upd_en    = ctrl_i.exec;
              upd_used  = 1'b0;
              upd_count = '0;
              upd_total = '0;
              upd_head  = '0;
            end
            CmdWait: begin
              if (cur_count != '0) begin
                upd_en    = ctrl_i.exec;
                upd_count = cur_count - count_t'(1);
              end else if (cur_total >= TotalW'(WaitDepth)) begin
                status_d = StQueueFull;
              end else begin
                upd_en    = ctrl_i.exec;
                upd_total = cur_total + total_t'(1);
                wr_en     = ctrl_i.exec;
                blocked_d = 1'b1;
              end
            end
            CmdSignal: begin
              if (cur_total != '0) begin
                upd_en       = ctrl_i.exec;
                upd_total    = cur_total - total_t'(1);
                upd_head     = head_next;
                wake_valid_d = 1'b1;
                woken_task_d = rd_task;
              end else if (cur_count == CountMax) begin
                status_d = StSaturated;
              end else begin
                upd_en    = ctrl_i.exec;
                upd_count = cur_count + count_t'(1);
              end
            end
            default: begin
              upd_en = 1'b0;
            end
          endcase
          count_value_d = CountW'(upd_count);
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSemaphores; i++) begin
        used_q[i]  <= 1'b0;
        count_q[i] <= '0;
        total_q[i] <= '0;
        head_q[i]  <= '0;
      end
    end else if (upd_en) begin
      used_q[upd_slot]  <= upd_used;
      count_q[upd_slot] <= upd_count;
      total_q[upd_slot] <= upd_total;
      head_q[upd_slot]  <= upd_head;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      status_q      <= status_d;
      new_handle_q  <= new_handle_d;
      count_value_q <= count_value_d;
      blocked_q     <= blocked_d;
      wake_valid_q  <= wake_valid_d;
      woken_task_q  <= woken_task_d;
    end
  end

  assign status_o      = status_q;
  assign new_handle_o  = new_handle_q;
  assign count_value_o = count_value_q;
  assign blocked_o     = blocked_q;
  assign wake_valid_o  = wake_valid_q;
  assign woken_task_o  = woken_task_q;

endmodule

/* rtl/counting_semaphore_table.sv */
// Table of counting semaphores driven by one command per transaction (create, destroy,
// wait, signal, get count); each command returns exactly one response. A command runs
// as a capture step, which captures it and reads the oldest waiter of the addressed slot
// from the waiter RAM, then an execute step, which does the read-modify-write of the
// slot and its queue and loads the response register. A new command is taken only when
// no response waits, or in the cycle that the waiting response is taken, and never
// during an execute step, so a stalled response stalls the command side. Wait queues
// are FIFO per slot; a woken task comes from the queue head. No clearing pass is needed
// after reset.
module counting_semaphore_table import cst_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  cst_cmd_if.sink   cmd_i,
  cst_rsp_if.source rsp_o
);

  cst_ctrl_t ctrl;

  cst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  cst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .command_i       (cmd_i.command),
    .handle_i        (cmd_i.handle),
    .start_count_i   (cmd_i.start_count),
    .task_id_i       (cmd_i.task_id),
    .status_o        (rsp_o.status),
    .new_handle_o    (rsp_o.new_handle),
    .count_value_o   (rsp_o.count_value),
    .blocked_o       (rsp_o.blocked),
    .wake_valid_o    (rsp_o.wake_valid),
    .woken_task_o    (rsp_o.woken_task)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cst_pkg::*;

  localparam int ItemsPerBlock = 100;
  localparam int RandomBlocks  = 12;
  localparam int CycleLimit    = 100000;
  localparam int IdlePercent   = 27;

  // Commands above the defined set are accepted and do nothing
  localparam int CmdFirstUnused = 5;
  localparam int CmdTopCode     = 7;

  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] new_handle;
    logic [CountW-1:0]  count_value;
    logic               blocked;
    logic               wake_valid;
    logic [TaskW-1:0]   woken_task;
  } reply_t;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [HandleW-1:0] handle;
    logic [InitW-1:0]   init;
    logic [TaskW-1:0]   tid;
    logic               typed;
    reply_t             want;
  } row_t;

  typedef enum int {MixBalanced, MixFill, MixDrain, MixChurn} mix_e;

  localparam reply_t NoReply = '0;

  localparam row_t DirectedPlan [25] = '{
    '{CmdGetCount, 3'd0, 16'h0000, 5'd0,  1'b1, '{StBadHandle, 3'd0, 16'h0000, 1'b0, 1'b0, 5'd0}},
    '{CmdCreate,   3'd0, 16'h0000, 5'd0,  1'b1, '{StOk,        3'd0, 16'h0000, 1'b0, 1'b0, 5'd0}},
    '{CmdCreate,   3'd0, 16'hFFFF, 5'd0,  1'b1, '{StOk,        3'd1, 16'hFFFF, 1'b0, 1'b0, 5'd0}},
    '{CmdSignal,   3'd1, 16'h0000, 5'd0,  1'b1, '{StSaturated, 3'd0, 16'hFFFF, 1'b0, 1'b0, 5'd0}},
    '{CmdWait,     3'd1, 16'h0000, 5'd21, 1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd0,  1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd31, 1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd10, 1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd21, 1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd5,  1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd26, 1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd1,  1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd30, 1'b0, NoReply},
    '{CmdWait,     3'd0, 16'h0000, 5'd7,  1'b1, '{StQueueFull, 3'd0, 16'h0000, 1'b0, 1'b0, 5'd0}},
    '{CmdSignal,   3'd0, 16'h0000, 5'd0,  1'b0, NoReply},
    '{3'(CmdFirstUnused), 3'd1, 16'hFFFF, 5'd31,
      1'b1, '{StOk, 3'd0, 16'h0000, 1'b0, 1'b0, 5'd0}},
    '{CmdCreate,   3'd0, 16'h5A5A, 5'd0,  1'b0, NoReply},
    '{CmdCreate,   3'd0, 16'hA5A5, 5'd0,  1'b0, NoReply},
    '{CmdCreate,   3'd0, 16'h0001, 5'd0,  1'b0, NoReply},
    '{CmdCreate,   3'd0, 16'h8000, 5'd0,  1'b0, NoReply},
    '{CmdCreate,   3'd0, 16'hFFFE, 5'd0,  1'b0, NoReply},
    '{CmdCreate,   3'd0, 16'h0003, 5'd0,  1'b0, NoReply},
    '{CmdCreate,   3'd0, 16'h1234, 5'd0,  1'b1, '{StNoSlot, 3'd0, 16'h0000, 1'b0, 1'b0, 5'd0}},
    '{CmdDestroy,  3'd7, 16'h0000, 5'd0,  1'b0, NoReply},
    '{CmdSignal,   3'd7, 16'h0000, 5'd0,  1'b1, '{StBadHandle, 3'd0, 16'h0000, 1'b0, 1'b0, 5'd0}}
  };

  logic clk;
  logic rst_n;
  bit   calm;
  int   errors;
  int   cycles;
  int   accepted;
  int   status_tally [5];
  int   wakeups;
  int   blocked_waits;

  // Semaphore table as the predictor sees it
  bit               in_use     [NumSemaphores];
  count_t           sem_cnt    [NumSemaphores];
  int unsigned      waiters    [NumSemaphores];
  int unsigned      head       [NumSemaphores];
  logic [TaskW-1:0] wait_queue [NumSemaphores][WaitDepth];

  reply_t owed_replies [$];

  cst_cmd_if cmd_bus ();
  cst_rsp_if rsp_bus ();

  counting_semaphore_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus.sink),
    .rsp_o  (rsp_bus.source)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d replies outstanding", $time, owed_replies.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic reply_t table_op(input logic [CmdW-1:0] c, input logic [HandleW-1:0] h,
                                      input logic [InitW-1:0] ic, input logic [TaskW-1:0] t);
    reply_t r;
    bit     found;
    r = NoReply;
    found = 1'b0;
    case (c)
      CmdCreate: begin
        r.status = StNoSlot;
        for (int s = 0; s < NumSemaphores && !found; s++) begin
          if (!in_use[s]) begin
            found = 1'b1;
            in_use[s] = 1'b1;
            sem_cnt[s] = count_t'(ic);
            waiters[s] = 0;
            head[s] = 0;
            r.status = StOk;
            r.new_handle = HandleW'(s);
            r.count_value = CountW'(sem_cnt[s]);
          end
        end
      end
      CmdDestroy, CmdWait, CmdSignal, CmdGetCount: begin
        if (h >= NumSemaphores || !in_use[h]) begin
          r.status = StBadHandle;
        end else begin
          case (c)
            CmdDestroy: begin
              in_use[h] = 1'b0;
              sem_cnt[h] = '0;
              waiters[h] = 0;
              head[h] = 0;
            end
            CmdWait: begin
              if (sem_cnt[h] != 0) begin
                sem_cnt[h] = sem_cnt[h] - 1'b1;
              end else if (waiters[h] >= WaitDepth) begin
                r.status = StQueueFull;
              end else begin
                wait_queue[h][(head[h] + waiters[h]) % WaitDepth] = t;
                waiters[h]++;
                r.blocked = 1'b1;
              end
            end
            CmdSignal: begin
              if (waiters[h] > 0) begin
                r.woken_task = wait_queue[h][head[h]];
                r.wake_valid = 1'b1;
                head[h] = (head[h] + 1) % WaitDepth;
                waiters[h]--;
              end else if (sem_cnt[h] == CountMax) begin
                r.status = StSaturated;
              end else begin
                sem_cnt[h] = sem_cnt[h] + 1'b1;
              end
            end
            default: ;
          endcase
          r.count_value = CountW'(sem_cnt[h]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [CmdW-1:0] pick_command(input mix_e mix);
    int roll;
    int cut [5];
    roll = $urandom_range(99);
    case (mix)
      MixFill:  cut = '{10, 13, 73, 90, 97};
      MixDrain: cut = '{10, 13, 28, 90, 97};
      MixChurn: cut = '{35, 65, 77, 89, 97};
      default:  cut = '{12, 18, 53, 85, 97};
    endcase
    if (roll < cut[0]) return CmdCreate;
    if (roll < cut[1]) return CmdDestroy;
    if (roll < cut[2]) return CmdWait;
    if (roll < cut[3]) return CmdSignal;
    if (roll < cut[4]) return CmdGetCount;
    return CmdW'($urandom_range(CmdFirstUnused, CmdTopCode));
  endfunction

  // Mostly live slots, sometimes any handle so free slots get hit too
  function automatic logic [HandleW-1:0] pick_handle();
    int live [$];
    for (int s = 0; s < NumSemaphores; s++)
      if (in_use[s]) live.push_back(s);
    if (live.size() != 0 && $urandom_range(99) < 85)
      return HandleW'(live[$urandom_range(live.size() - 1)]);
    return HandleW'($urandom_range(NumSemaphores - 1));
  endfunction

  function automatic logic [InitW-1:0] pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return InitW'($urandom_range(3));
    if (roll < 65) return InitW'(CountMax) - InitW'($urandom_range(1));
    return InitW'($urandom_range(16'hFFFF));
  endfunction

  task automatic send(input logic [CmdW-1:0] c, input logic [HandleW-1:0] h,
                      input logic [InitW-1:0] ic, input logic [TaskW-1:0] t,
                      input logic typed, input reply_t want);
    reply_t predicted;
    while (!calm && $urandom_range(99) < IdlePercent) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.command     <= c;
    cmd_bus.handle      <= h;
    cmd_bus.start_count <= ic;
    cmd_bus.task_id     <= t;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    predicted = table_op(c, h, ic, t);
    owed_replies.push_back(typed ? want : predicted);
    accepted++;
    status_tally[predicted.status]++;
    wakeups += predicted.wake_valid;
    blocked_waits += predicted.blocked;
  endtask

  task automatic check_reply();
    reply_t      want;
    logic [31:0] wf [6];
    logic [31:0] gf [6];
    string       names [6];
    names = '{"status", "new_handle", "count_value", "blocked", "wake_valid", "woken_task"};
    if (owed_replies.size() == 0) begin
      $display("%0t: reply with nothing outstanding: status %0d count %0d", $time,
               rsp_bus.status, rsp_bus.count_value);
      errors++;
      return;
    end
    want = owed_replies.pop_front();
    wf = '{want.status, want.new_handle, want.count_value, want.blocked,
           want.wake_valid, want.woken_task};
    gf = '{rsp_bus.status, rsp_bus.new_handle, rsp_bus.count_value, rsp_bus.blocked,
           rsp_bus.wake_valid, rsp_bus.woken_task};
    for (int i = 0; i < 6; i++) begin
      if (gf[i] !== wf[i]) begin
        $display("%0t: %s expected %0d got %0d", $time, names[i], wf[i], gf[i]);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_bus.valid && rsp_bus.ready) check_reply();
      rsp_bus.ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  initial begin
    mix_e mix;
    logic [CmdW-1:0] c;
    clk = 1'b0;
    rst_n = 1'b0;
    calm = 1'b0;
    cmd_bus.valid = 1'b0;
    cmd_bus.command = CmdGetCount;
    cmd_bus.handle = '0;
    cmd_bus.start_count = '0;
    cmd_bus.task_id = '0;
    rsp_bus.ready = 1'b0;
    for (int s = 0; s < NumSemaphores; s++) begin
      in_use[s] = 1'b0;
      sem_cnt[s] = '0;
      waiters[s] = 0;
      head[s] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DirectedPlan); i++)
      send(DirectedPlan[i].cmd, DirectedPlan[i].handle, DirectedPlan[i].init,
           DirectedPlan[i].tid, DirectedPlan[i].typed, DirectedPlan[i].want);

    for (int blk = 0; blk < RandomBlocks; blk++) begin
      mix = mix_e'(blk % 4);
      calm <= (blk == 4 || blk == 5);
      // Hold off until the table has answered everything in flight
      if (blk == 6) begin
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (owed_replies.size() != 0) @(posedge clk);
      end
      for (int n = 0; n < ItemsPerBlock; n++) begin
        c = pick_command(mix);
        send(c, pick_handle(), pick_count(), TaskW'($urandom_range(31)), 1'b0, NoReply);
      end
    end

    cmd_bus.valid <= 1'b0;
    calm <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d commands, %0d blocked waits, %0d wakeups", accepted,
             blocked_waits, wakeups);
    $display("summary: ok %0d, no slot %0d, bad handle %0d, queue full %0d, saturated %0d",
             status_tally[StOk], status_tally[StNoSlot], status_tally[StBadHandle],
             status_tally[StQueueFull], status_tally[StSaturated]);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
